>>> hdl/dlcts_pkg.sv
package dlcts_pkg;

	// Number of schedule segments that take part in the search (2..6)
	localparam int SEGMENT_COUNT = 6;
	// Segment registers present on the config port
	localparam int SEG_REGS = 6;

	localparam int MINUTE_W = 11;
	localparam int MINUTES_PER_HOUR = 60;

	// Lighting modes
	typedef enum logic [1:0] {
		MODE_DAY   = 2'd0,
		MODE_NIGHT = 2'd1,
		MODE_OFF   = 2'd2
	} mode_t;

	// Switch mode register codes
	typedef enum logic [1:0] {
		SW_OFF   = 2'd0,
		SW_NIGHT = 2'd1,
		SW_DAY   = 2'd2,
		SW_AUTO  = 2'd3
	} sw_mode_t;

	// Config register indexes
	typedef enum logic [2:0] {
		REG_SEG0   = 3'd0,
		REG_SEG1   = 3'd1,
		REG_SEG2   = 3'd2,
		REG_SEG3   = 3'd3,
		REG_SEG4   = 3'd4,
		REG_SEG5   = 3'd5,
		REG_WINDOW = 3'd6,
		REG_SWITCH = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [MINUTE_W-1:0] start;
	} seg_cfg_t;

	typedef seg_cfg_t [SEG_REGS-1:0] seg_array_t;

	typedef struct packed {
		logic [MINUTE_W-1:0] off_minute;
		logic [MINUTE_W-1:0] on_minute;
	} gas_window_t;

	// Input transaction
	typedef struct packed {
		logic [4:0] clock_hour;
		logic [5:0] clock_minute;
	} tick_t;

	// Result transaction
	typedef struct packed {
		logic       main_lamp;
		logic       day_lamp;
		logic       gas_valve;
		logic [1:0] chosen_mode;
	} drive_t;

	// Mode codes other than day and night read as off
	function automatic mode_t normalize_mode(logic [1:0] m);
		mode_t r;
		r = MODE_OFF;
		if (m == MODE_DAY) begin
			r = MODE_DAY;
		end else if (m == MODE_NIGHT) begin
			r = MODE_NIGHT;
		end
		return r;
	endfunction

endpackage

>>> hdl/daily_light_co2_time_switch.sv
// Channel  | Handshake                     | Payload
// tick     | tick_valid / tick_stall       | tick (clock_hour, clock_minute)
// drive    | drive_valid / drive_stall     | drive (lamps, valve, chosen_mode)
// cfg      | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One tick accepted per cycle while tick_stall is low; its result passes through the
// tick register, then the result register. The schedule search and window compare sit
// between the two registers. Reset clears valid flags, config and valve hold.
// A stalled result holds the result register and stalls tick only when the
// tick register is also full. cfg_ready is always high.
module daily_light_co2_time_switch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  dlcts_pkg::tick_t  tick,
	output logic              drive_valid,
	input  logic              drive_stall,
	output dlcts_pkg::drive_t drive,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [21:0]       cfg_data
);
	import dlcts_pkg::*;

	seg_array_t  segments_q;
	gas_window_t gas_window_q;
	sw_mode_t    switch_mode_q;
	logic        valve_hold_q;

	logic   valid_s1;
	tick_t  tick_s1;
	logic   drive_valid_q;
	drive_t drive_q;

	logic   move_s1;
	logic   take_tick;
	drive_t result;
	logic   valve_next;

	assign cfg_ready = 1'b1;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q    <= '0;
			gas_window_q  <= '0;
			switch_mode_q <= SW_OFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_SEG0:   segments_q[0] <= seg_cfg_t'(cfg_data[12:0]);
				REG_SEG1:   segments_q[1] <= seg_cfg_t'(cfg_data[12:0]);
				REG_SEG2:   segments_q[2] <= seg_cfg_t'(cfg_data[12:0]);
				REG_SEG3:   segments_q[3] <= seg_cfg_t'(cfg_data[12:0]);
				REG_SEG4:   segments_q[4] <= seg_cfg_t'(cfg_data[12:0]);
				REG_SEG5:   segments_q[5] <= seg_cfg_t'(cfg_data[12:0]);
				REG_WINDOW: gas_window_q  <= gas_window_t'(cfg_data);
				REG_SWITCH: switch_mode_q <= sw_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves when the result register is free or draining
	assign move_s1    = valid_s1 && (!drive_valid_q || !drive_stall);
	assign tick_stall = valid_s1 && !move_s1;
	assign take_tick  = tick_valid && !tick_stall;

	// Tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_tick) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			tick_s1 <= tick;
		end
	end

	dlcts_eval u_eval (
		.tick        (tick_s1),
		.segments    (segments_q),
		.gas_window  (gas_window_q),
		.switch_mode (switch_mode_q),
		.valve_hold  (valve_hold_q),
		.result      (result),
		.valve_next  (valve_next)
	);

	// Result register and valve hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
			valve_hold_q  <= 1'b0;
		end else if (move_s1) begin
			drive_valid_q <= 1'b1;
			valve_hold_q  <= valve_next;
		end else if (!drive_stall) begin
			drive_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			drive_q <= result;
		end
	end

	assign drive_valid = drive_valid_q;
	assign drive       = drive_q;

`ifndef ASSERT_OFF
	a_day_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid_q && drive_q.day_lamp |-> drive_q.main_lamp)
		else $error("day lamp on without main lamp");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid_q |-> (drive_q.chosen_mode == MODE_DAY ||
			drive_q.chosen_mode == MODE_NIGHT || drive_q.chosen_mode == MODE_OFF))
		else $error("result carries an undefined mode code");

	a_manual_holds_valve: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 && switch_mode_q != SW_AUTO |=> $stable(valve_hold_q))
		else $error("valve hold changed in a manual mode");

	a_valve_matches_hold: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> drive_q.gas_valve == valve_hold_q)
		else $error("result valve differs from held valve");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> valid_s1 && drive_valid_q && drive_stall)
		else $error("tick stalled while pipeline has room");
`endif

endmodule

>>> hdl/dlcts_eval.sv
module dlcts_eval (
	input  dlcts_pkg::tick_t       tick,
	input  dlcts_pkg::seg_array_t  segments,
	input  dlcts_pkg::gas_window_t gas_window,
	input  dlcts_pkg::sw_mode_t    switch_mode,
	input  logic                   valve_hold,
	output dlcts_pkg::drive_t      result,
	output logic                   valve_next
);
	import dlcts_pkg::*;

	localparam int LAST = SEGMENT_COUNT - 1;

	logic [MINUTE_W-1:0] now;
	logic [1:0]          sched_raw;
	mode_t               mode;
	logic                window_hit;

	// Minute of day: hour * 60 as (hour << 6) - (hour << 2)
	assign now = MINUTE_W'({tick.clock_hour, 6'b0}) - MINUTE_W'({tick.clock_hour, 2'b0})
		+ MINUTE_W'(tick.clock_minute);

	// Highest segment started strictly before now; last segment wraps over midnight
	always_comb begin
		sched_raw = segments[LAST].mode;
		for (int k = 0; k < SEGMENT_COUNT; k++) begin
			if (now > segments[k].start) begin
				sched_raw = segments[k].mode;
			end
		end
	end

	// CO2 window, no wrap
	assign window_hit = (gas_window.on_minute <= now) && (now < gas_window.off_minute);

	// Mode select; manual modes keep the held valve value
	always_comb begin
		valve_next = valve_hold;
		case (switch_mode)
			SW_AUTO: begin
				mode       = normalize_mode(sched_raw);
				valve_next = window_hit;
			end
			SW_DAY:   mode = MODE_DAY;
			SW_NIGHT: mode = MODE_NIGHT;
			default:  mode = MODE_OFF;
		endcase
	end

	assign result.main_lamp   = (mode == MODE_DAY) || (mode == MODE_NIGHT);
	assign result.day_lamp    = (mode == MODE_DAY);
	assign result.gas_valve   = valve_next;
	assign result.chosen_mode = mode;

endmodule

>>> test/lamp_schedule_checker.sv
module lamp_schedule_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	input  logic              tick_stall,
	input  dlcts_pkg::tick_t  tick,
	input  logic              drive_valid,
	input  logic              drive_stall,
	input  dlcts_pkg::drive_t drive,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [21:0]       cfg_data,
	output int                errors,
	output int                pending
);
	import dlcts_pkg::*;

	// Shadow copy of the block's settings and valve memory
	seg_array_t  segs;
	gas_window_t window;
	sw_mode_t    switch_sel;
	logic        valve_hold;

	// Lamp/valve drives owed to the drive channel, oldest first
	drive_t scheduled_drives[$];
	drive_t want;

	// Lamp and valve drive for one clock tick; updates the valve memory in auto mode
	function automatic drive_t plan_drive(tick_t t);
		int         now;
		int         k;
		logic [1:0] code;
		mode_t      lamp_mode;
		drive_t     d;
		now = t.clock_hour * MINUTES_PER_HOUR + t.clock_minute;
		lamp_mode = MODE_OFF;
		case (switch_sel)
		SW_AUTO: begin
			// nothing started yet today: last segment carries over from yesterday
			code = segs[SEGMENT_COUNT-1].mode;
			for (k = 0; k < SEGMENT_COUNT; k++) begin
				if (now > segs[k].start)
					code = segs[k].mode;
			end
			// unused mode code reads as off
			if (code == MODE_DAY)
				lamp_mode = MODE_DAY;
			else if (code == MODE_NIGHT)
				lamp_mode = MODE_NIGHT;
			// no wrap: an empty or inverted window keeps the valve shut
			valve_hold = (now >= window.on_minute) && (now < window.off_minute);
		end
		SW_DAY:   lamp_mode = MODE_DAY;
		SW_NIGHT: lamp_mode = MODE_NIGHT;
		default:  lamp_mode = MODE_OFF;
		endcase
		d.main_lamp   = (lamp_mode != MODE_OFF);
		d.day_lamp    = (lamp_mode == MODE_DAY);
		d.gas_valve   = valve_hold;
		d.chosen_mode = lamp_mode;
		return d;
	endfunction

	task automatic compare_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			errors++;
			$display("%0t: drive.%s expected %0d, got %0d", $time, name, exp_val, got_val);
		end
	endtask

	// Follow config writes, queue a drive per accepted tick, check each drive transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs = '0;
			window = '0;
			switch_sel = SW_OFF;
			valve_hold = 1'b0;
			scheduled_drives.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
				REG_WINDOW: window = cfg_data;
				REG_SWITCH: switch_sel = sw_mode_t'(cfg_data[1:0]);
				default:    segs[cfg_index] = cfg_data[12:0];
				endcase
			end
			if (tick_valid && !tick_stall)
				scheduled_drives.push_back(plan_drive(tick));
			if (drive_valid && !drive_stall) begin
				if (scheduled_drives.size() == 0) begin
					errors++;
					$display("%0t: drive transaction %h with none expected", $time, drive);
				end else begin
					want = scheduled_drives.pop_front();
					compare_field("main_lamp", want.main_lamp, drive.main_lamp);
					compare_field("day_lamp", want.day_lamp, drive.day_lamp);
					compare_field("gas_valve", want.gas_valve, drive.gas_valve);
					compare_field("chosen_mode", want.chosen_mode, drive.chosen_mode);
				end
			end
			pending = scheduled_drives.size();
		end
	end

endmodule

>>> test/daily_light_co2_time_switch_tb.sv
module daily_light_co2_time_switch_tb;
	import dlcts_pkg::*;

	localparam int WATCHDOG_LIMIT  = 1000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_PHASES   = 10;
	localparam int TICKS_PER_PHASE = 63;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        tick_valid = 1'b0;
	logic        tick_stall;
	tick_t       tick = '0;
	logic        drive_valid;
	logic        drive_stall = 1'b0;
	drive_t      drive;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [21:0] cfg_data = '0;

	int errors;
	int pending;

	// Register values for the current setting
	logic [21:0] reg_image [8];

	int gap_pct = 0;
	int stall_pct = 0;
	int ticks_sent = 0;
	int settings_used = 0;
	int quiet = 0;
	int p;
	int n;

	always #6 clk = ~clk;

	daily_light_co2_time_switch u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	lamp_schedule_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.drive_valid (drive_valid),
		.drive_stall (drive_stall),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending)
	);

	function automatic tick_t tick_at(input int h, input int m);
		tick_t t;
		t.clock_hour = 5'(h);
		t.clock_minute = 6'(m);
		return t;
	endfunction

	// Mostly in-range times, some at or next to a segment start or window edge, some out of range
	function automatic tick_t draw_tick();
		int pick;
		int k;
		int now;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return tick_at($urandom_range(0, 23), $urandom_range(0, 59));
		if (pick < 9) begin
			k = $urandom_range(0, 7);
			if (k < 6)
				now = reg_image[k][10:0];
			else if (k == 6)
				now = reg_image[REG_WINDOW][10:0];
			else
				now = reg_image[REG_WINDOW][21:11];
			now = now + $urandom_range(0, 2) - 1;
			if (now < 0)
				now = 0;
			if (now > 1919)
				now = 1919;
			return tick_at(now / 60, now % 60);
		end
		return tick_at($urandom_range(0, 31), $urandom_range(0, 63));
	endfunction

	// Random schedule; unused upper data bits are randomized too
	task automatic draw_settings(input bit ascending);
		int k;
		int pick;
		int start;
		int on_min;
		int off_min;
		start = 0;
		for (k = REG_SEG0; k <= REG_SEG5; k++) begin
			pick = $urandom_range(0, 9);
			if (ascending)
				start = start + $urandom_range(0, 320);
			else if (pick == 0)
				start = 0;
			else if (pick == 1)
				start = 2047;
			else if (pick == 2)
				start = $urandom_range(0, 2047);
			else
				start = $urandom_range(0, 1439);
			reg_image[k] = {9'($urandom), 2'($urandom_range(0, 3)), 11'(start)};
		end
		pick = $urandom_range(0, 9);
		on_min = $urandom_range(0, 1439);
		off_min = on_min + $urandom_range(1, 600);
		if (pick == 0) begin
			off_min = $urandom_range(0, on_min);
		end else if (pick == 1) begin
			on_min = $urandom_range(0, 2047);
			off_min = $urandom_range(0, 2047);
		end
		reg_image[REG_WINDOW] = {11'(off_min), 11'(on_min)};
		if ($urandom_range(0, 9) < 7)
			reg_image[REG_SWITCH] = {20'($urandom), SW_AUTO};
		else
			reg_image[REG_SWITCH] = {20'($urandom), 2'($urandom_range(0, 2))};
	endtask

	// Write the selected registers back to back, then drop valid
	task automatic apply_settings(input bit [7:0] which);
		int k;
		for (k = 0; k < 8; k++) begin
			if (which[k]) begin
				cfg_index <= 3'(k);
				cfg_data <= reg_image[k];
				cfg_valid <= 1'b1;
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
			end
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_tick(input tick_t t);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
		tick <= t;
		tick_valid <= 1'b1;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Block is idle once every queued drive has come back
	task automatic settle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
	endtask

	// Result-side backpressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				drive_stall <= 1'b1;
				repeat ($urandom_range(1, 7))
					@(posedge clk);
				drive_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long with no transaction on any channel
	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (drive_valid && !drive_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d drives outstanding",
					$time, quiet, pending);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 25;
		stall_pct = 25;

		// reset settings: forced off, field extremes
		send_tick(tick_at(0, 0));
		send_tick(tick_at(31, 63));
		settle();

		// six-segment day with an unused mode code, an unreachable start and wrap
		reg_image[REG_SEG0] = 22'({MODE_DAY, 11'd360});
		reg_image[REG_SEG1] = 22'({MODE_NIGHT, 11'd720});
		reg_image[REG_SEG2] = 22'({2'b11, 11'd1080});
		reg_image[REG_SEG3] = 22'({MODE_OFF, 11'd1320});
		reg_image[REG_SEG4] = 22'({MODE_DAY, 11'd2047});
		reg_image[REG_SEG5] = 22'({MODE_NIGHT, 11'd1400});
		reg_image[REG_WINDOW] = {11'd960, 11'd480};
		reg_image[REG_SWITCH] = 22'(SW_AUTO);
		apply_settings(8'hFF);
		send_tick(tick_at(0, 0));
		send_tick(tick_at(6, 0));
		send_tick(tick_at(6, 1));
		send_tick(tick_at(15, 59));
		send_tick(tick_at(16, 0));
		send_tick(tick_at(18, 0));
		send_tick(tick_at(18, 1));
		send_tick(tick_at(23, 20));
		send_tick(tick_at(23, 59));
		send_tick(tick_at(31, 63));
		send_tick(tick_at(8, 0));
		settle();

		// manual modes hold the valve from the last automatic tick
		reg_image[REG_SWITCH] = 22'(SW_DAY);
		apply_settings(8'b1 << REG_SWITCH);
		send_tick(tick_at(0, 0));
		settle();
		reg_image[REG_SWITCH] = 22'(SW_NIGHT);
		apply_settings(8'b1 << REG_SWITCH);
		send_tick(tick_at(23, 59));
		settle();
		reg_image[REG_SWITCH] = 22'(SW_OFF);
		apply_settings(8'b1 << REG_SWITCH);
		send_tick(tick_at(12, 0));
		settle();

		// all-ones settings, then inverted window and a segment starting at midnight
		for (n = REG_SEG0; n <= REG_SEG5; n++)
			reg_image[n] = 22'({2'b11, 11'h7FF});
		reg_image[REG_WINDOW] = 22'h3FFFFF;
		reg_image[REG_SWITCH] = 22'(SW_AUTO);
		apply_settings(8'hFF);
		send_tick(tick_at(12, 0));
		settle();
		reg_image[REG_WINDOW] = {11'd500, 11'd1000};
		reg_image[REG_SEG0] = 22'({MODE_DAY, 11'd0});
		apply_settings((8'b1 << REG_WINDOW) | (8'b1 << REG_SEG0));
		send_tick(tick_at(16, 40));
		send_tick(tick_at(0, 0));
		send_tick(tick_at(0, 1));

		// random schedules; idling varies per phase, none at the end
		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			draw_settings(p[0]);
			apply_settings(8'hFF);
			if (p >= RANDOM_PHASES - 2) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case (p % 3)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 20;
					stall_pct = 20;
				end
				default: begin
					gap_pct = 50;
					stall_pct = 40;
				end
				endcase
			end
			for (n = 0; n < TICKS_PER_PHASE; n++)
				send_tick(draw_tick());
		end

		settle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("Sent %0d clock ticks under %0d register settings:", ticks_sent, settings_used);
		$display("forced and automatic switching, midnight wrap, odd codes, CO2 window edges.");
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
